@@ rtl/lsws_pkg.sv @@
package lsws_pkg;

  // default number of entries
  localparam int unsigned DefStackDepth = 64;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_FIND  = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_FIND,
    S_READ
  } state_e;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [31:0]  value;
    logic [5:0]          position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [5:0]          found_position;
    logic signed [31:0]  found_value;
    logic signed [31:0]  top_value;
    logic                is_empty;
    logic [6:0]          entry_count;
  } res_t;

endpackage

@@ rtl/lsws_mem.sv @@
module lsws_mem
  import lsws_pkg::*;
#(
  parameter int unsigned Depth = DefStackDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read: data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lsws_ctrl.sv @@
module lsws_ctrl
  import lsws_pkg::*;
#(
  parameter int unsigned StackDepth = DefStackDepth,
  parameter int unsigned AddrW      = $clog2(StackDepth),
  parameter int unsigned CntW       = $clog2(StackDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              res_valid_o,
  output res_t              res_o,
  output logic              mem_we_o,
  output logic [AddrW-1:0]  mem_waddr_o,
  output logic [31:0]       mem_wdata_o,
  output logic [AddrW-1:0]  mem_raddr_o,
  input  logic [31:0]       mem_rdata_i
);

  localparam int unsigned CmpW = (CntW > 6) ? CntW : 6;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [31:0]        top_q, top_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]   rd_addr_q, rd_addr_d;
  logic [31:0]        val_q, val_d;
  status_e            status_q, status_d;
  logic [5:0]         fpos_q, fpos_d;
  logic [31:0]        fval_q, fval_d;
  logic               res_valid_q, done;
  logic               accept, full;
  logic [CmpW-1:0]    pos_ext, cnt_ext;

  assign accept  = start && (state_q == S_IDLE);
  assign full    = (count_q == CntW'(StackDepth));
  assign pos_ext = CmpW'(cmd_i.position);
  assign cnt_ext = CmpW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    idx_q     <= idx_d;
    rd_addr_q <= rd_addr_d;
    val_q     <= val_d;
    if (done) begin
      status_q <= status_d;
      fpos_q   <= fpos_d;
      fval_q   <= fval_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    idx_d       = idx_q;
    rd_addr_d   = rd_addr_q;
    val_d       = val_q;
    mem_raddr_o = rd_addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AddrW-1:0];
    mem_wdata_o = cmd_i.value;
    done        = 1'b0;
    status_d    = ST_OK;
    fpos_d      = '0;
    fval_d      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = cmd_i.value;
          case (cmd_i.op)
            OP_PUSH: begin
              done = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CntW'(1);
                top_d    = cmd_i.value;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                done     = 1'b1;
              end else if (count_q == CntW'(1)) begin
                count_d = '0;
                done    = 1'b1;
              end else begin
                // fetch the entry that becomes the new top
                count_d     = count_q - CntW'(1);
                mem_raddr_o = AddrW'(count_q - CntW'(2));
                state_d     = S_POP;
              end
            end
            OP_FIND: begin
              if (count_q == '0) begin
                status_d = ST_MISS;
                done     = 1'b1;
              end else begin
                mem_raddr_o = AddrW'(count_q - CntW'(1));
                rd_addr_d   = mem_raddr_o;
                idx_d       = '0;
                state_d     = S_FIND;
              end
            end
            OP_READ: begin
              if (pos_ext < cnt_ext) begin
                mem_raddr_o = AddrW'(cnt_ext - CmpW'(1) - pos_ext);
                idx_d       = AddrW'(cmd_i.position);
                state_d     = S_READ;
              end else begin
                status_d = ST_MISS;
                done     = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              done    = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        top_d   = mem_rdata_i;
        done    = 1'b1;
        state_d = S_IDLE;
      end
      S_READ: begin
        fpos_d  = 6'(idx_q);
        fval_d  = mem_rdata_i;
        done    = 1'b1;
        state_d = S_IDLE;
      end
      S_FIND: begin
        // read data belongs to position idx_q, one entry per cycle
        if (mem_rdata_i == val_q) begin
          fpos_d  = 6'(idx_q);
          fval_d  = mem_rdata_i;
          done    = 1'b1;
          state_d = S_IDLE;
        end else if ((CntW'(idx_q) + CntW'(1)) == count_q) begin
          status_d = ST_MISS;
          done     = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_raddr_o = rd_addr_q - AddrW'(1);
          rd_addr_d   = mem_raddr_o;
          idx_d       = idx_q + AddrW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o                = '0;
    res_o.status         = status_q;
    res_o.found_position = fpos_q;
    res_o.found_value    = fval_q;
    res_o.top_value      = (count_q != '0) ? top_q : '0;
    res_o.is_empty       = (count_q == '0);
    res_o.entry_count    = 7'(count_q);
  end

endmodule

@@ rtl/lifo_stack_with_search.sv @@
// channel    | handshake              | payload
// -----------+------------------------+-----------------
// command in | start high, busy low   | cmd_i (cmd_t)
// result out | res_valid_o one cycle  | res_o (res_t)
//
// push, clear, unused codes, a pop of the last entry and failing pop, find
// or read finish in the accept cycle; other pops and read at position go
// through S_POP or S_READ, for the store's registered read port
// find walks the entries down from the top until a match or the bottom;
// the single read port scans one entry per cycle
// the result strobes in the cycle after the command's final state, and the
// receiver cannot stall it; a new command may be taken in that same cycle
// reset clears the fill count and control state only; the store is
// never cleared, entries above the fill count are simply not read
module lifo_stack_with_search
  import lsws_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  cmd_t  cmd_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  // store port between sequencer and memory
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [31:0]       mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [31:0]       mem_rdata;

  // sequencer: fill count, cached top value, find walk, result register
  lsws_ctrl #(
    .StackDepth (STACK_DEPTH),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry 0 is the bottom of the stack
  lsws_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  // an accepted command either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("accepted command neither busy nor finished");

  // leaving a multi-cycle operation always delivers its result
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result transfer");

  // an empty stack reports a zero top value
  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_empty) |-> (res_o.top_value == '0))
    else $error("empty stack with nonzero top value");
`endif

endmodule
